// ===== src/bcah_pkg.sv =====
package bcah_pkg;

  localparam int BUTTONS_DEF = 4;
  localparam int HOLD_STEP = 5;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  // register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_PRESSED_LEVEL = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HOLD_PERIOD = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RELEASE_DELAY = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PRESS_LIMIT = 3'd3;
  localparam logic [CFG_AW-1:0] REG_HOLD_LIMIT = 3'd4;
  localparam logic [CFG_AW-1:0] REG_UNKNOWN_CODE = 3'd5;

  localparam logic OP_LEVEL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_HOLD = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_PENDING,
    HS_ARMED
  } hold_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LVL_RD,
    ST_LVL_WR,
    ST_HOLD_RD,
    ST_HOLD_WR,
    ST_REL_RD,
    ST_REL_WR,
    ST_FLUSH
  } st_t;

  typedef struct packed {
    logic       pressed;
    logic       released;
    logic       holding;
    logic [3:0] clicks;
    logic [7:0] holds;
  } btn_ent_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] btn;
    logic [7:0] code;
    logic       last;
  } rpt_t;

  // h / 5 for an 8-bit h: multiply by 205/1024, exact over 0..255
  function automatic logic [5:0] div5(input logic [7:0] h);
    logic [15:0] p;
    p = 16'(h) * 16'd205;
    return p[15:10];
  endfunction

endpackage

// ===== src/button_click_and_hold_classifier_top.sv =====
// Click and hold classifier for a small set of buttons.
// Input stream: one word per event. in_tuser = 0 is a settled level change of
// button in_tdata[1:0] to level in_tdata[2]; in_tuser = 1 is a millisecond tick.
// Output stream: reports. out_tuser is the kind (0 hold progress, 1 final),
// out_tdata holds the button and the code, out_tlast marks the last report of
// the tick that caused it. Level changes give no report.
// Per-button flags and counts live in a small synchronous RAM, one entry per
// button; each access is a read cycle followed by a modify/write cycle.
// A level change is accepted, then read and written back. A tick starts a
// hold pass and then a release pass over all buttons when each is due (either
// may be skipped), then closes the report burst; the RAM walk steps one button
// per read and modify/write pair.
// Reports leave through an output register; the next event is taken while the
// last report still waits there. A stalled receiver freezes the walk at the
// next report until the output register drains.
// Reset (rst_n, synchronous, active low) clears all buttons through per-entry
// valid bits at once, stops both timers and restores the register defaults.
module button_click_and_hold_classifier_top
  import bcah_pkg::*;
#(
  parameter int BUTTONS = BUTTONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [1:0] button, [2] level
  input  logic              in_tuser,   // [0] op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [1:0] button_index, [9:2] code
  output logic              out_tuser,  // [0] report_kind
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(BUTTONS - 1);

  // configuration
  logic        plevel_r;
  logic [15:0] hperiod_r;
  logic [15:0] rdelay_r;
  logic [3:0]  plimit_r;
  logic [7:0]  hlimit_r;
  logic [7:0]  ucode_r;

  st_t         state_r, state_nxt;
  hold_st_t    hs_r, hs_nxt;
  logic [15:0] htmr_r, htmr_nxt;
  logic        rel_arm_r, rel_arm_nxt;
  logic [15:0] rel_cnt_r, rel_cnt_nxt;
  logic        rel_run_r, rel_run_nxt;
  logic        any_r, any_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic        lvl_r, lvl_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  rpt_t        pend_r, pend_nxt;
  logic        out_vld_r, out_vld_nxt;
  rpt_t        out_r, out_nxt;

  btn_ent_t    mem_r [BUTTONS];
  logic [BUTTONS-1:0] vld_r;
  btn_ent_t    rd_q_r;
  logic        rd_vld_r;

  logic        mem_we;
  btn_ent_t    mem_wd;
  logic        vld_wd;

  logic        accept;
  logic        in_op;
  logic [1:0]  in_btn;
  logic        btn_ok;
  logic        hold_go;
  logic        rel_go;
  logic        slot_free;
  logic        stall;
  logic        emit;
  rpt_t        emit_rpt;
  btn_ent_t    ent;
  btn_ent_t    ent_new;
  logic [7:0]  h1;
  logic [5:0]  q5;
  logic [7:0]  rem5;
  logic [7:0]  hcode;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign in_op      = in_tuser;
  assign in_btn     = in_tdata[1:0];
  assign btn_ok     = (32'(in_btn) < BUTTONS);
  assign slot_free  = !out_vld_r || out_tready;
  assign ent        = rd_vld_r ? rd_q_r : '0;

  assign hold_go = (hs_r == HS_PENDING) || ((hs_r == HS_ARMED) && (htmr_r <= 16'd1));
  assign rel_go  = rel_arm_r && (rel_cnt_r <= 16'd1);

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_r.code, out_r.btn};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

  // per-button arithmetic for the current entry
  always_comb begin
    h1    = (ent.holds == 8'hFF) ? 8'hFF : ent.holds + 8'd1;
    q5    = div5(rd_q_r.holds);
    if (state_r == ST_HOLD_WR) begin
      q5 = div5(h1);
    end
    rem5  = h1 - 8'(q5) * 8'(HOLD_STEP);
    hcode = 8'(q5) + 8'(plimit_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_LEVEL) begin
            if (btn_ok) state_nxt = ST_LVL_RD;
          end else if (hold_go) begin
            state_nxt = ST_HOLD_RD;
          end else if (rel_go) begin
            state_nxt = ST_REL_RD;
          end
        end
      end
      ST_LVL_RD:  state_nxt = ST_LVL_WR;
      ST_LVL_WR:  state_nxt = ST_IDLE;
      ST_HOLD_RD: state_nxt = ST_HOLD_WR;
      ST_HOLD_WR: begin
        if (!stall) begin
          if (idx_r != LAST_IDX) state_nxt = ST_HOLD_RD;
          else if (rel_run_r) state_nxt = ST_REL_RD;
          else state_nxt = ST_FLUSH;
        end
      end
      ST_REL_RD:  state_nxt = ST_REL_WR;
      ST_REL_WR: begin
        if (!stall) begin
          state_nxt = (idx_r != LAST_IDX) ? ST_REL_RD : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_r || slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    hs_nxt       = hs_r;
    htmr_nxt     = htmr_r;
    rel_arm_nxt  = rel_arm_r;
    rel_cnt_nxt  = rel_cnt_r;
    rel_run_nxt  = rel_run_r;
    any_nxt      = any_r;
    idx_nxt      = idx_r;
    lvl_nxt      = lvl_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_tready ? 1'b0 : out_vld_r;
    out_nxt      = out_r;
    mem_we       = 1'b0;
    mem_wd       = ent;
    vld_wd       = 1'b1;
    emit         = 1'b0;
    emit_rpt     = '0;
    ent_new      = ent;
    stall        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          any_nxt = 1'b0;
          if (in_op == OP_LEVEL) begin
            idx_nxt = IW'(in_btn);
            lvl_nxt = in_tdata[2];
          end else begin
            if (hs_r == HS_ARMED && htmr_r > 16'd1) htmr_nxt = htmr_r - 16'd1;
            rel_run_nxt = rel_go;
            if (rel_arm_r) begin
              if (rel_go) begin
                rel_arm_nxt = 1'b0;
                rel_cnt_nxt = '0;
              end else begin
                rel_cnt_nxt = rel_cnt_r - 16'd1;
              end
            end
          end
        end
      end

      ST_LVL_WR: begin
        mem_we = 1'b1;
        if (lvl_r == plevel_r) begin
          ent_new.clicks  = (ent.clicks == 4'hF) ? 4'hF : ent.clicks + 4'd1;
          ent_new.holding = 1'b0;
          ent_new.holds   = '0;
          ent_new.pressed = 1'b1;
          ent_new.released = 1'b0;
          if (!ent.pressed) begin
            hs_nxt   = HS_PENDING;
            htmr_nxt = '0;
          end
        end else begin
          ent_new.released = 1'b1;
          ent_new.pressed  = 1'b0;
          rel_arm_nxt = 1'b1;
          rel_cnt_nxt = rdelay_r;
        end
        mem_wd = ent_new;
      end

      ST_HOLD_WR: begin
        if (ent.pressed) begin
          ent_new.holds = h1;
          if (h1 >= 8'(HOLD_STEP)) begin
            ent_new.holding = 1'b1;
            ent_new.clicks  = '0;
          end
          emit = (rem5 == 8'd0);
          emit_rpt = '{kind: KIND_HOLD, btn: 2'(idx_r), code: hcode, last: 1'b0};
        end
        stall = emit && pend_vld_r && !slot_free;
        if (!stall) begin
          mem_we = ent.pressed;
          mem_wd = ent_new;
          if (idx_r != LAST_IDX) begin
            idx_nxt = idx_r + IW'(1);
            any_nxt = any_r | ent.pressed;
          end else begin
            idx_nxt = '0;
            if (any_r | ent.pressed) begin
              hs_nxt   = HS_ARMED;
              htmr_nxt = hperiod_r;
            end else begin
              hs_nxt   = HS_IDLE;
              htmr_nxt = '0;
            end
          end
        end
      end

      ST_REL_WR: begin
        if (ent.released) begin
          emit = 1'b1;
          emit_rpt.kind = KIND_FINAL;
          emit_rpt.btn  = 2'(idx_r);
          if (!ent.holding) begin
            emit_rpt.code = (ent.clicks >= plimit_r) ? ucode_r : 8'(ent.clicks);
          end else begin
            emit_rpt.code = (hcode >= hlimit_r) ? ucode_r : hcode;
          end
        end
        stall = emit && pend_vld_r && !slot_free;
        if (!stall) begin
          // clear the button by dropping its valid bit
          mem_we = ent.released;
          vld_wd = 1'b0;
          if (idx_r != LAST_IDX) idx_nxt = idx_r + IW'(1);
        end
      end

      ST_FLUSH: begin
        if (pend_vld_r && slot_free) begin
          out_vld_nxt  = 1'b1;
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
          pend_vld_nxt = 1'b0;
        end
      end

      default: ;
    endcase

    // hold each report back one step so the last of a burst can be marked
    if (emit && !stall) begin
      if (pend_vld_r) begin
        out_vld_nxt = 1'b1;
        out_nxt     = pend_r;
      end
      pend_vld_nxt = 1'b1;
      pend_nxt     = emit_rpt;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r   <= mem_r[idx_r];
    rd_vld_r <= vld_r[idx_r];
    if (mem_we) begin
      mem_r[idx_r] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[idx_r] <= vld_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plevel_r  <= 1'b0;
      hperiod_r <= 16'd200;
      rdelay_r  <= 16'd500;
      plimit_r  <= 4'd6;
      hlimit_r  <= 8'd10;
      ucode_r   <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PRESSED_LEVEL: plevel_r  <= cfg_wdata[0];
        REG_HOLD_PERIOD:   hperiod_r <= cfg_wdata;
        REG_RELEASE_DELAY: rdelay_r  <= cfg_wdata;
        REG_PRESS_LIMIT:   plimit_r  <= cfg_wdata[3:0];
        REG_HOLD_LIMIT:    hlimit_r  <= cfg_wdata[7:0];
        REG_UNKNOWN_CODE:  ucode_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      hs_r       <= HS_IDLE;
      htmr_r     <= '0;
      rel_arm_r  <= 1'b0;
      rel_cnt_r  <= '0;
      rel_run_r  <= 1'b0;
      any_r      <= 1'b0;
      idx_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hs_r       <= hs_nxt;
      htmr_r     <= htmr_nxt;
      rel_arm_r  <= rel_arm_nxt;
      rel_cnt_r  <= rel_cnt_nxt;
      rel_run_r  <= rel_run_nxt;
      any_r      <= any_nxt;
      idx_r      <= idx_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r  <= lvl_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule
